### hdl/ssrp_pkg.sv
// ssrp_pkg: shared types, constants and byte pick helper for the string replace unit
// no dependencies; imported by ssrp_cfg, ssrp_seq and stream_string_replace_pad_unit
`default_nettype none

package ssrp_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = PAT_IDX_W + 1;
    localparam int PAT_BITS    = MAX_PATTERN * 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HI   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPLACE_HI  = 3'd5;

    typedef struct packed {
        logic [LEN_W-1:0]    tgt_len;
        logic [LEN_W-1:0]    rep_len;
        logic [PAT_BITS-1:0] tgt;
        logic [PAT_BITS-1:0] rep;
    } t_cfg;

    typedef struct packed {
        logic                 busy;
        logic [PAT_IDX_W-1:0] idx;
        logic [PAT_IDX_W-1:0] last;
    } t_seq_status;

    function automatic logic [7:0] pick_byte(input logic [PAT_BITS-1:0] vec,
                                             input logic [PAT_IDX_W-1:0] idx);
        pick_byte = vec[idx*8 +: 8];
    endfunction

endpackage

`default_nettype wire

### hdl/ssrp_cfg.sv
// ssrp_cfg: configuration registers and clamped lengths
// depends on ssrp_pkg
`default_nettype none

module ssrp_cfg
    import ssrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [LEN_W-1:0]      r_tgt_len;
    logic [LEN_W-1:0]      r_rep_len;
    logic [CFG_DATA_W-1:0] r_tgt_lo;
    logic [CFG_DATA_W-1:0] r_tgt_hi;
    logic [CFG_DATA_W-1:0] r_rep_lo;
    logic [CFG_DATA_W-1:0] r_rep_hi;
    logic [LEN_W-1:0]      tl_eff;
    logic [LEN_W-1:0]      rl_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_len <= LEN_W'(1);
            r_rep_len <= LEN_W'(1);
            r_tgt_lo  <= '0;
            r_tgt_hi  <= '0;
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_LEN:  r_tgt_len <= i_cfg_data[LEN_W-1:0];
                REG_REPLACE_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                REG_TARGET_LO:   r_tgt_lo  <= i_cfg_data;
                REG_TARGET_HI:   r_tgt_hi  <= i_cfg_data;
                REG_REPLACE_LO:  r_rep_lo  <= i_cfg_data;
                REG_REPLACE_HI:  r_rep_hi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tgt_len == '0) begin
            tl_eff = LEN_W'(1);
        end else if (r_tgt_len > LEN_W'(MAX_PATTERN)) begin
            tl_eff = LEN_W'(MAX_PATTERN);
        end else begin
            tl_eff = r_tgt_len;
        end
        if (r_rep_len == '0) begin
            rl_eff = LEN_W'(1);
        end else if (r_rep_len > tl_eff) begin
            rl_eff = tl_eff;
        end else begin
            rl_eff = r_rep_len;
        end
    end

    assign o_cfg.tgt_len = tl_eff;
    assign o_cfg.rep_len = rl_eff;
    assign o_cfg.tgt     = PAT_BITS'({r_tgt_hi, r_tgt_lo});
    assign o_cfg.rep     = PAT_BITS'({r_rep_hi, r_rep_lo});

endmodule

`default_nettype wire

### hdl/ssrp_seq.sv
// ssrp_seq: match counter, emit sequencer with byte pickers on one shared index, output register
// depends on ssrp_pkg
`default_nettype none

module ssrp_seq
    import ssrp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_stream,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last,
    output t_seq_status     o_status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state               r_state,  n_state;
    logic [PAT_IDX_W-1:0] r_mcount, n_mcount;
    logic [PAT_IDX_W-1:0] r_idx,    n_idx;
    logic [PAT_IDX_W-1:0] r_last,   n_last;
    logic [LEN_W-1:0]     r_held,   n_held;
    logic                 r_repl,   n_repl;
    logic [7:0]           r_byte,   n_byte;
    logic                 r_ovalid, n_ovalid;
    logic [7:0]           r_obyte,  n_obyte;
    logic                 r_olast,  n_olast;

    logic [PAT_IDX_W-1:0] sel_idx;
    logic [7:0]           tbyte;
    logic [7:0]           rbyte;
    logic [7:0]           emit_byte;
    logic [LEN_W-1:0]     m1;
    logic [LEN_W-1:0]     tl_m1;
    logic                 hit;
    logic                 slot_free;

    // one picker index, from match count while idle, from beat index while emitting
    assign sel_idx   = (r_state == S_IDLE) ? r_mcount : r_idx;
    assign tbyte     = pick_byte(i_cfg.tgt, sel_idx);
    assign rbyte     = pick_byte(i_cfg.rep, sel_idx);
    assign m1        = {1'b0, r_mcount} + LEN_W'(1);
    assign tl_m1     = i_cfg.tgt_len - LEN_W'(1);
    assign hit       = ({1'b0, r_mcount} < i_cfg.tgt_len) && (i_in_byte == tbyte);
    assign slot_free = !r_ovalid || !i_out_stall;

    always_comb begin
        if (r_repl) begin
            emit_byte = ({1'b0, r_idx} < i_cfg.rep_len) ? rbyte : SPACE_CHAR;
        end else begin
            emit_byte = ({1'b0, r_idx} < r_held) ? tbyte : r_byte;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mcount = r_mcount;
        n_idx    = r_idx;
        n_last   = r_last;
        n_held   = r_held;
        n_repl   = r_repl;
        n_byte   = r_byte;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_olast  = r_olast;
        if (slot_free) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx  = '0;
                    n_byte = i_in_byte;
                    if (hit && (m1 == i_cfg.tgt_len)) begin
                        n_repl   = 1'b1;
                        n_last   = tl_m1[PAT_IDX_W-1:0];
                        n_mcount = '0;
                        n_state  = S_EMIT;
                    end else if (hit && i_end_of_stream) begin
                        n_repl   = 1'b0;
                        n_held   = m1;
                        n_last   = r_mcount;
                        n_mcount = '0;
                        n_state  = S_EMIT;
                    end else if (hit) begin
                        n_mcount = m1[PAT_IDX_W-1:0];
                    end else begin
                        n_repl   = 1'b0;
                        n_held   = {1'b0, r_mcount};
                        n_last   = r_mcount;
                        n_mcount = '0;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    n_obyte  = emit_byte;
                    n_olast  = (r_idx == r_last);
                    n_idx    = r_idx + PAT_IDX_W'(1);
                    if (r_idx == r_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mcount <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mcount <= n_mcount;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_last  <= n_last;
        r_held  <= n_held;
        r_repl  <= n_repl;
        r_byte  <= n_byte;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_run_last    = r_olast;
    assign o_status.busy = (r_state == S_EMIT);
    assign o_status.idx  = r_idx;
    assign o_status.last = r_last;

endmodule

`default_nettype wire

### hdl/stream_string_replace_pad_unit.sv
// stream_string_replace_pad_unit: top level of the streaming string replace with space padding
// depends on ssrp_pkg, ssrp_cfg, ssrp_seq
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall    i_in_byte, i_end_of_stream
//   out      source     o_out_valid / i_out_stall  o_out_byte, o_run_last
//   cfg      sink       i_cfg_we                   i_cfg_idx, i_cfg_data
//
// an item that only extends a partial match leaves the sequencer idle; one that emits beats
// stalls the input while the emit sequencer produces one beat per cycle, unless the output
// stalls, through the byte pickers on one shared index. reset is synchronous, active low,
// and clears the match count. a stalled output holds the sequencer; the next item is taken
// while the final beat still waits in the output register.
`default_nettype none

module stream_string_replace_pad_unit
    import ssrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_end_of_stream,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_run_last
);

    t_cfg        cfg;
    t_seq_status seq_st;

    ssrp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ssrp_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last),
        .o_status        (seq_st)
    );

`ifndef NO_ASSERTIONS
    a_stalled_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_run_last)))
        else $error("stalled output beat changed or dropped");

    a_done_shows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> (o_out_valid && o_run_last))
        else $error("sequencer went idle without loading the final beat");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_st.busy |-> (seq_st.idx <= seq_st.last))
        else $error("emit index ran past the last beat");

    a_busy_is_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_st.busy == o_in_stall)
        else $error("input stall does not follow the sequencer");
`endif

endmodule

`default_nettype wire
